// ===== sv/tcis_pkg.sv =====
// Shared types and constants for the teaching CPU step block.
// Holds the beat structs, opcode/status/action codes and the controller interface.
`default_nettype none
package tcis_pkg;

    localparam int DEF_REGISTER_COUNT = 8;
    localparam int DEF_DATA_DEPTH     = 256;
    localparam int DEF_PROGRAM_DEPTH  = 256;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 14;

    localparam logic [CFG_INDEX_W-1:0] CFG_PROGRAM_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_STEPS      = 1'b1;

    localparam logic [8:0]  PROGRAM_LENGTH_RESET = 9'd0;
    localparam logic [13:0] MAX_STEPS_RESET      = 14'd10000;

    localparam logic [2:0] ACT_LOAD_INSTR = 3'd0;
    localparam logic [2:0] ACT_WRITE_DATA = 3'd1;
    localparam logic [2:0] ACT_EXECUTE    = 3'd2;
    localparam logic [2:0] ACT_READ_DATA  = 3'd3;
    localparam logic [2:0] ACT_READ_REG   = 3'd4;

    localparam logic [4:0] OP_NOP   = 5'd0;
    localparam logic [4:0] OP_HALT  = 5'd1;
    localparam logic [4:0] OP_ADD   = 5'd2;
    localparam logic [4:0] OP_SUB   = 5'd3;
    localparam logic [4:0] OP_MUL   = 5'd4;
    localparam logic [4:0] OP_DIV   = 5'd5;
    localparam logic [4:0] OP_AND   = 5'd6;
    localparam logic [4:0] OP_OR    = 5'd7;
    localparam logic [4:0] OP_XOR   = 5'd8;
    localparam logic [4:0] OP_ADDI  = 5'd9;
    localparam logic [4:0] OP_MOVI  = 5'd10;
    localparam logic [4:0] OP_LOAD  = 5'd11;
    localparam logic [4:0] OP_STORE = 5'd12;
    localparam logic [4:0] OP_CMP   = 5'd13;
    localparam logic [4:0] OP_BEQ   = 5'd14;
    localparam logic [4:0] OP_BNE   = 5'd15;
    localparam logic [4:0] OP_BLT   = 5'd16;
    localparam logic [4:0] OP_BGT   = 5'd17;
    localparam logic [4:0] OP_JMP   = 5'd18;

    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_HALTED     = 3'd1;
    localparam logic [2:0] STAT_REFUSED    = 3'd2;
    localparam logic [2:0] STAT_DIV_ZERO   = 3'd3;
    localparam logic [2:0] STAT_BAD_ADDR   = 3'd4;
    localparam logic [2:0] STAT_BAD_PC     = 3'd5;
    localparam logic [2:0] STAT_BAD_TARGET = 3'd6;
    localparam logic [2:0] STAT_STEP_LIMIT = 3'd7;

    typedef struct packed {
        logic [2:0]         action;
        logic [7:0]         location;
        logic signed [31:0] value;
        logic [4:0]         opcode;
        logic [2:0]         dest_reg;
        logic [2:0]         src_reg_a;
        logic [2:0]         src_reg_b;
        logic signed [31:0] immediate;
        logic [7:0]         branch_target;
    } item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] read_data;
        logic [8:0]         next_pc;
        logic               zero_flag;
        logic               negative_flag;
        logic               branch_taken;
    } result_t;

    typedef struct packed {
        logic [4:0]  opcode;
        logic [2:0]  dest_reg;
        logic [2:0]  src_reg_a;
        logic [2:0]  src_reg_b;
        logic [31:0] immediate;
        logic [7:0]  target;
    } slot_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DECODE,
        ST_EXEC,
        ST_DIV,
        ST_LOAD,
        ST_WB,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        EX_FINISH,
        EX_WRITEBACK,
        EX_DIVIDE,
        EX_LOAD
    } exec_kind_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic read;
        logic check;
        logic decode;
        logic exec;
        logic div_wait;
        logic load;
        logic wb;
    } ctl_cmd_t;

    typedef struct packed {
        logic       clear_last;
        logic       acc_exec;
        logic       acc_read;
        logic       check_stop;
        exec_kind_t ex_kind;
        logic       div_done;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== sv/teaching_cpu_instruction_step.sv =====
// Top level of the teaching CPU step block: controller plus datapath.
// Depends on tcis_pkg, tcis_ctl, tcis_dp (and tcis_div below it).
//
// One item per start beat, taken when start is high and busy is low; its single
// result beat shows on result for exactly one cycle with done high, and must be
// taken then, since the receiver cannot hold it off. After reset the block
// clears data memory one word per cycle, so busy stays high until every word is
// cleared, before the first item; config writes are taken at any time. States
// from accept to done: load instruction, write data and unknown actions go to
// DONE directly; read data and read register pass READ; a refused step or one
// faulted before fetch passes CHECK; an executed instruction passes CHECK, DECODE
// and EXEC (branches, compare, store, nop, halt, faults found at execute), then
// WB for a register writeback, LOAD and WB for a data memory load, or DIV and
// WB for a divide, whose iterative divider takes one quotient bit per cycle.
// Config writes belong to idle periods only.
`default_nettype none
module teaching_cpu_instruction_step #(
    parameter int REGISTER_COUNT = tcis_pkg::DEF_REGISTER_COUNT,
    parameter int DATA_DEPTH     = tcis_pkg::DEF_DATA_DEPTH,
    parameter int PROGRAM_DEPTH  = tcis_pkg::DEF_PROGRAM_DEPTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire tcis_pkg::item_t                  item,
    output logic                                  done,
    output tcis_pkg::result_t                     result,
    input  wire logic                             cfg_we,
    input  wire logic [tcis_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tcis_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tcis_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    // sequencer: owns the phase, tells the datapath what to do each cycle
    tcis_ctl u_ctl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // datapath: all storage, ALU, divider and the result registers
    tcis_dp #(
        .REGISTER_COUNT (REGISTER_COUNT),
        .DATA_DEPTH     (DATA_DEPTH),
        .PROGRAM_DEPTH  (PROGRAM_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

`ifndef NO_ASSERTIONS
    // a result beat lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held longer than one cycle");

    // an accepted beat makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // no result without an item in flight
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done while idle");

    // pc never exceeds the largest program length
    assert property (@(posedge clk) disable iff (!rst_n) done |-> (result.next_pc <= 9'd256))
        else $error("pc out of range");
`endif

endmodule
`default_nettype wire

// ===== sv/tcis_div.sv =====
// Iterative unsigned 32-bit divider, one quotient bit per cycle.
// Depends on nothing; the datapath handles signs.
`default_nettype none
module tcis_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg, quo_reg, dsr_reg;
    logic [32:0] rem_sh, diff;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[31]};
        diff   = rem_sh - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
        end
        else if (busy_reg && (cnt_reg == 5'd31))
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            if (start)
            begin
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
            end
        end
    end

    // shift in one dividend bit, subtract when it fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (diff[32])
            begin
                rem_reg <= rem_sh[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
            else
            begin
                rem_reg <= diff[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ===== sv/tcis_dp.sv =====
// Datapath of the teaching CPU: program store, data memory, register file,
// ALU, flags, pc and run state. Depends on tcis_pkg and tcis_div.
`default_nettype none
module tcis_dp #(
    parameter int REGISTER_COUNT = tcis_pkg::DEF_REGISTER_COUNT,
    parameter int DATA_DEPTH     = tcis_pkg::DEF_DATA_DEPTH,
    parameter int PROGRAM_DEPTH  = tcis_pkg::DEF_PROGRAM_DEPTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire tcis_pkg::ctl_cmd_t                  cmd,
    output tcis_pkg::dp_stat_t                       stat,
    input  wire tcis_pkg::item_t                     item,
    input  wire logic                                cfg_we,
    input  wire logic [tcis_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [tcis_pkg::CFG_DATA_W-1:0]     cfg_data,
    output tcis_pkg::result_t                        result
);
    import tcis_pkg::*;

    localparam int RI_W = $clog2(REGISTER_COUNT);
    localparam int DA_W = $clog2(DATA_DEPTH);
    localparam int PA_W = $clog2(PROGRAM_DEPTH);
    localparam logic [31:0] DATA_DEPTH_W = 32'(DATA_DEPTH);
    localparam logic [31:0] PROG_DEPTH_W = 32'(PROGRAM_DEPTH);
    localparam logic [5:0]  RC_W         = 6'(REGISTER_COUNT);
    localparam logic [DA_W-1:0] CLEAR_LAST = DA_W'(DATA_DEPTH - 1);

    typedef enum logic [1:0] {
        RUN_RUNNING,
        RUN_HALTED,
        RUN_FAULTED
    } run_t;

    // register number modulo the register count, one bit per step
    function automatic logic [RI_W-1:0] reg_sel(input logic [7:0] v);
        logic [5:0] r;
        r = '0;
        for (int i = 7; i >= 0; i--)
        begin
            r = {r[4:0], v[i]};
            if (r >= RC_W)
            begin
                r = r - RC_W;
            end
        end
        return RI_W'(r);
    endfunction

    slot_t       prog_mem [PROGRAM_DEPTH];
    logic [31:0] dmem     [DATA_DEPTH];
    logic [31:0] rf_reg   [REGISTER_COUNT];

    item_t       item_reg;
    slot_t       prog_q_reg;
    logic [31:0] dm_q_reg, rf_q_reg, a_reg, b_reg, wb_reg;
    logic        flag_en_reg, q_neg_reg;
    logic [8:0]  pc_reg;
    logic        zf_reg, nf_reg;
    run_t        run_reg;
    logic [13:0] steps_reg;
    logic [8:0]  plen_reg;
    logic [13:0] maxs_reg;
    logic [2:0]  res_status_reg;
    logic [31:0] res_data_reg;
    logic        res_taken_reg;
    logic [DA_W-1:0] clr_reg;

    logic [31:0] eff_len, mem_addr, diff_ab, alu_val, mag_a, mag_b;
    logic        loc_in_data, loc_in_prog, reg_loc_in_data;
    logic        stopped, step_lim, pc_bad, addr_ok, tgt_ok, cond;
    exec_kind_t  ex_kind;
    logic        dm_we, dm_re;
    logic [DA_W-1:0] dm_waddr, dm_raddr;
    logic [31:0] dm_wdata;
    logic        div_start, div_done;
    logic [31:0] div_quo;

    always_comb
    begin
        eff_len = (32'(plen_reg) > PROG_DEPTH_W) ? PROG_DEPTH_W : 32'(plen_reg);
        loc_in_data     = 32'(item.location) < DATA_DEPTH_W;
        loc_in_prog     = 32'(item.location) < PROG_DEPTH_W;
        reg_loc_in_data = 32'(item_reg.location) < DATA_DEPTH_W;
        stopped  = run_reg != RUN_RUNNING;
        step_lim = steps_reg >= maxs_reg;
        pc_bad   = 32'(pc_reg) >= eff_len;

        mem_addr = ((prog_q_reg.opcode == OP_LOAD) ? a_reg : b_reg) + prog_q_reg.immediate;
        addr_ok  = !mem_addr[31] && (mem_addr < DATA_DEPTH_W);
        tgt_ok   = 32'(prog_q_reg.target) < eff_len;
        diff_ab  = a_reg - b_reg;
        mag_a    = a_reg[31] ? (~a_reg + 32'd1) : a_reg;
        mag_b    = b_reg[31] ? (~b_reg + 32'd1) : b_reg;

        case (prog_q_reg.opcode)
            OP_ADD:  alu_val = a_reg + b_reg;
            OP_SUB:  alu_val = diff_ab;
            OP_MUL:  alu_val = a_reg * b_reg;
            OP_AND:  alu_val = a_reg & b_reg;
            OP_OR:   alu_val = a_reg | b_reg;
            OP_XOR:  alu_val = a_reg ^ b_reg;
            OP_ADDI: alu_val = a_reg + prog_q_reg.immediate;
            OP_MOVI: alu_val = prog_q_reg.immediate;
            default: alu_val = '0;
        endcase

        case (prog_q_reg.opcode)
            OP_BEQ:  cond = zf_reg;
            OP_BNE:  cond = !zf_reg;
            OP_BLT:  cond = nf_reg;
            OP_BGT:  cond = !zf_reg && !nf_reg;
            OP_JMP:  cond = 1'b1;
            default: cond = 1'b0;
        endcase

        case (prog_q_reg.opcode)
            OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_ADDI, OP_MOVI:
                ex_kind = EX_WRITEBACK;
            OP_DIV:  ex_kind = (b_reg == 32'd0) ? EX_FINISH : EX_DIVIDE;
            OP_LOAD: ex_kind = addr_ok ? EX_LOAD : EX_FINISH;
            default: ex_kind = EX_FINISH;
        endcase

        div_start = cmd.exec && (prog_q_reg.opcode == OP_DIV) && (b_reg != 32'd0);

        // single write port: clearing pass, host write, store
        dm_we    = 1'b0;
        dm_waddr = clr_reg;
        dm_wdata = '0;
        if (cmd.clear)
        begin
            dm_we = 1'b1;
        end
        else if (cmd.accept && (item.action == ACT_WRITE_DATA) && loc_in_data)
        begin
            dm_we    = 1'b1;
            dm_waddr = DA_W'(item.location);
            dm_wdata = item.value;
        end
        else if (cmd.exec && (prog_q_reg.opcode == OP_STORE) && addr_ok)
        begin
            dm_we    = 1'b1;
            dm_waddr = DA_W'(mem_addr);
            dm_wdata = a_reg;
        end

        dm_re    = 1'b0;
        dm_raddr = DA_W'(item.location);
        if (cmd.accept)
        begin
            dm_re = 1'b1;
        end
        else if (cmd.exec && (prog_q_reg.opcode == OP_LOAD))
        begin
            dm_re    = 1'b1;
            dm_raddr = DA_W'(mem_addr);
        end
    end

    tcis_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_a),
        .divisor  (mag_b),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            dmem[dm_waddr] <= dm_wdata;
        end
        if (dm_re)
        begin
            dm_q_reg <= dmem[dm_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && (item.action == ACT_LOAD_INSTR) && loc_in_prog)
        begin
            prog_mem[PA_W'(item.location)] <= '{opcode:    item.opcode,
                                                dest_reg:  item.dest_reg,
                                                src_reg_a: item.src_reg_a,
                                                src_reg_b: item.src_reg_b,
                                                immediate: $unsigned(item.immediate),
                                                target:    item.branch_target};
        end
        if (cmd.check)
        begin
            prog_q_reg <= prog_mem[PA_W'(pc_reg)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REGISTER_COUNT; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else if (cmd.wb)
        begin
            rf_reg[reg_sel({5'd0, prog_q_reg.dest_reg})] <= wb_reg;
        end
    end

    // payload: accepted item, register read value, operands, writeback value
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= item;
            rf_q_reg <= rf_reg[reg_sel(item.location)];
        end
        if (cmd.decode)
        begin
            a_reg <= rf_reg[reg_sel({5'd0, prog_q_reg.src_reg_a})];
            b_reg <= rf_reg[reg_sel({5'd0, prog_q_reg.src_reg_b})];
        end
        if (cmd.exec)
        begin
            wb_reg      <= alu_val;
            flag_en_reg <= prog_q_reg.opcode != OP_LOAD;
            q_neg_reg   <= a_reg[31] ^ b_reg[31];
        end
        if (cmd.div_wait && div_done)
        begin
            wb_reg <= q_neg_reg ? (~div_quo + 32'd1) : div_quo;
        end
        if (cmd.load)
        begin
            wb_reg <= dm_q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg       <= PROGRAM_LENGTH_RESET;
            maxs_reg       <= MAX_STEPS_RESET;
            clr_reg        <= '0;
            pc_reg         <= '0;
            zf_reg         <= 1'b0;
            nf_reg         <= 1'b0;
            run_reg        <= RUN_RUNNING;
            steps_reg      <= '0;
            res_status_reg <= STAT_OK;
            res_data_reg   <= '0;
            res_taken_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PROGRAM_LENGTH: plen_reg <= cfg_data[8:0];
                    CFG_MAX_STEPS:      maxs_reg <= cfg_data;
                    default:            ;
                endcase
            end
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.accept)
            begin
                res_status_reg <= STAT_OK;
                res_data_reg   <= '0;
                res_taken_reg  <= 1'b0;
            end
            if (cmd.read)
            begin
                if (item_reg.action == ACT_READ_REG)
                begin
                    res_data_reg <= rf_q_reg;
                end
                else if (reg_loc_in_data)
                begin
                    res_data_reg <= dm_q_reg;
                end
                else
                begin
                    res_status_reg <= STAT_BAD_ADDR;
                end
            end
            if (cmd.check)
            begin
                if (stopped)
                begin
                    res_status_reg <= STAT_REFUSED;
                end
                else if (step_lim)
                begin
                    res_status_reg <= STAT_STEP_LIMIT;
                    run_reg        <= RUN_FAULTED;
                end
                else if (pc_bad)
                begin
                    res_status_reg <= STAT_BAD_PC;
                    run_reg        <= RUN_FAULTED;
                end
            end
            if (cmd.decode)
            begin
                pc_reg <= pc_reg + 9'd1;
            end
            if (cmd.exec)
            begin
                case (prog_q_reg.opcode)
                    OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_ADDI, OP_MOVI:
                        ;
                    OP_DIV:
                        if (b_reg == 32'd0)
                        begin
                            res_status_reg <= STAT_DIV_ZERO;
                            run_reg        <= RUN_FAULTED;
                        end
                    OP_LOAD, OP_STORE:
                        if (!addr_ok)
                        begin
                            res_status_reg <= STAT_BAD_ADDR;
                            run_reg        <= RUN_FAULTED;
                        end
                        else if (prog_q_reg.opcode == OP_STORE)
                        begin
                            steps_reg <= steps_reg + 14'd1;
                        end
                    OP_CMP:
                    begin
                        zf_reg    <= diff_ab == 32'd0;
                        nf_reg    <= diff_ab[31];
                        steps_reg <= steps_reg + 14'd1;
                    end
                    OP_BEQ, OP_BNE, OP_BLT, OP_BGT, OP_JMP:
                        if (cond && !tgt_ok)
                        begin
                            res_status_reg <= STAT_BAD_TARGET;
                            run_reg        <= RUN_FAULTED;
                        end
                        else
                        begin
                            if (cond)
                            begin
                                pc_reg        <= {1'b0, prog_q_reg.target};
                                res_taken_reg <= 1'b1;
                            end
                            steps_reg <= steps_reg + 14'd1;
                        end
                    OP_HALT:
                    begin
                        steps_reg      <= steps_reg + 14'd1;
                        run_reg        <= RUN_HALTED;
                        res_status_reg <= STAT_HALTED;
                    end
                    default:
                        steps_reg <= steps_reg + 14'd1;
                endcase
            end
            if (cmd.wb)
            begin
                if (flag_en_reg)
                begin
                    zf_reg <= wb_reg == 32'd0;
                    nf_reg <= wb_reg[31];
                end
                res_data_reg <= wb_reg;
                steps_reg    <= steps_reg + 14'd1;
            end
        end
    end

    always_comb
    begin
        stat.clear_last = clr_reg == CLEAR_LAST;
        stat.acc_exec   = item.action == ACT_EXECUTE;
        stat.acc_read   = (item.action == ACT_READ_DATA) || (item.action == ACT_READ_REG);
        stat.check_stop = stopped || step_lim || pc_bad;
        stat.ex_kind    = ex_kind;
        stat.div_done   = div_done;

        result.status        = res_status_reg;
        result.read_data     = $signed(res_data_reg);
        result.next_pc       = pc_reg;
        result.zero_flag     = zf_reg;
        result.negative_flag = nf_reg;
        result.branch_taken  = res_taken_reg;
    end

endmodule
`default_nettype wire

// ===== sv/tcis_ctl.sv =====
// Controller state machine of the teaching CPU: sequences clearing, access
// and instruction phases. Depends on tcis_pkg.
`default_nettype none
module tcis_ctl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire tcis_pkg::dp_stat_t  stat,
    output tcis_pkg::ctl_cmd_t       cmd,
    output logic                     busy,
    output logic                     done
);
    import tcis_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = state_reg != ST_IDLE;
        done       = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (stat.acc_exec)
                    begin
                        state_next = ST_CHECK;
                    end
                    else if (stat.acc_read)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_DONE;
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.check_stop ? ST_DONE : ST_DECODE;
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                case (stat.ex_kind)
                    EX_WRITEBACK: state_next = ST_WB;
                    EX_DIVIDE:    state_next = ST_DIV;
                    EX_LOAD:      state_next = ST_LOAD;
                    default:      state_next = ST_DONE;
                endcase
            end
            ST_DIV:
            begin
                cmd.div_wait = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_WB;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_WB;
            end
            ST_WB:
            begin
                cmd.wb     = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire
